// ===== design/hbs_pkg.sv =====
package hbs_pkg;

  localparam int unsigned BIN_W      = 9;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned RAD_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // Window step counters run from 0 to twice the radius.
  localparam int unsigned STEP_W = RAD_W + 1;

  localparam logic [BIN_W-1:0] BINS_RESET   = 9'd256;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINS_X        = 3'd0,
    CFG_BINS_Y        = 3'd1,
    CFG_SMOOTH_RADIUS = 3'd2,
    CFG_X_PERIODIC    = 3'd3,
    CFG_Y_PERIODIC    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef struct packed {
    logic [BIN_W-1:0] bins_x;
    logic [BIN_W-1:0] bins_y;
    logic [RAD_W-1:0] smooth_radius;
    logic             x_periodic;
    logic             y_periodic;
  } cfg_t;

endpackage

// ===== design/hbs_ram.sv =====
module hbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hbs_fifo.sv =====
module hbs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = data_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/hbs_front.sv =====
module hbs_front import hbs_pkg::*; #(
  parameter int unsigned MAX_BINS_X = 256,
  parameter int unsigned MAX_BINS_Y = 256,
  localparam int unsigned XW = $clog2(MAX_BINS_X + 2),
  localparam int unsigned YW = $clog2(MAX_BINS_Y + 2),
  localparam int unsigned EW = 2 + XW + YW + COUNT_W
) (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [BIN_W-1:0]          bin_x_i,
  input  logic [BIN_W-1:0]          bin_y_i,
  input  logic signed [COUNT_W-1:0] count_in_i,
  input  cfg_t                      cfg_i,
  input  logic                      clear_busy_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output logic [EW-1:0]             push_data_o
);

  logic [XW-1:0] nx, x_over, x;
  logic [YW-1:0] ny, y_over, y;
  logic          border;

  // Bin counts of zero act as one, and counts above the store size act as the maximum.
  always_comb begin
    if (cfg_i.bins_x == '0) begin
      nx = XW'(1);
    end else if (32'(cfg_i.bins_x) > MAX_BINS_X) begin
      nx = XW'(MAX_BINS_X);
    end else begin
      nx = XW'(cfg_i.bins_x);
    end
    if (cfg_i.bins_y == '0) begin
      ny = YW'(1);
    end else if (32'(cfg_i.bins_y) > MAX_BINS_Y) begin
      ny = YW'(MAX_BINS_Y);
    end else begin
      ny = YW'(cfg_i.bins_y);
    end
  end

  assign x_over = nx + XW'(1);
  assign y_over = ny + YW'(1);

  // Indices past the overflow bin fold onto it.
  assign x = (32'(bin_x_i) > 32'(x_over)) ? x_over : XW'(bin_x_i);
  assign y = (32'(bin_y_i) > 32'(y_over)) ? y_over : YW'(bin_y_i);

  assign border = (x == '0) || (y == '0) || (x == x_over) || (y == y_over);

  assign in_ready_o   = push_ready_i && !clear_busy_i;
  assign push_valid_o = in_valid_i && !clear_busy_i;
  assign push_data_o  = {func_i, border, x, y, count_in_i};

endmodule

// ===== design/hbs_back.sv =====
module hbs_back import hbs_pkg::*; #(
  parameter int unsigned MAX_BINS_X = 256,
  parameter int unsigned MAX_BINS_Y = 256,
  parameter int unsigned MAX_RADIUS = 7,
  localparam int unsigned XW = $clog2(MAX_BINS_X + 2),
  localparam int unsigned YW = $clog2(MAX_BINS_Y + 2),
  localparam int unsigned EW = 2 + XW + YW + COUNT_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    pop_valid_i,
  output logic                    pop_ready_o,
  input  logic [EW-1:0]           pop_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SUM_W-1:0] sum_o,
  output logic                    clear_busy_o
);

  localparam int unsigned STRIDE = MAX_BINS_X + 2;
  localparam int unsigned DEPTH  = (MAX_BINS_X + 2) * (MAX_BINS_Y + 2);
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SXW    = XW + 6;
  localparam int unsigned SYW    = YW + 6;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic [XW-1:0]     cur_x_q, cur_x_d;
  logic [YW-1:0]     cur_y_q, cur_y_d;
  logic              cur_border_q, cur_border_d;
  logic [XW-1:0]     x_ptr_q, x_ptr_d;
  logic [YW-1:0]     y_ptr_q, y_ptr_d;
  logic [YW-1:0]     y_start_q, y_start_d;
  logic [STEP_W-1:0] kx_q, kx_d;
  logic [STEP_W-1:0] ky_q, ky_d;
  logic [RAD_W-1:0]  scnt_q, scnt_d;
  logic              v1_q, v1_d;
  logic              last1_q, last1_d;
  logic [XW-1:0]     nbx_q, nbx_d;
  logic [YW-1:0]     nby_q, nby_d;
  logic              v2_q;
  logic              last2_q;
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] out_sum_q, out_sum_d;

  logic                      e_func;
  logic                      e_border;
  logic [XW-1:0]             e_x;
  logic [YW-1:0]             e_y;
  logic signed [COUNT_W-1:0] e_count;

  logic [XW-1:0]     nx;
  logic [YW-1:0]     ny;
  logic [RAD_W-1:0]  r;
  logic [STEP_W-1:0] two_r;
  logic [SXW-1:0]    px_raw;
  logic [SYW-1:0]    py_raw;
  logic [XW-1:0]     px_clamp, x_inc, x_dec;
  logic [YW-1:0]     py_clamp, y_inc, y_dec;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;

  assign {e_func, e_border, e_x, e_y, e_count} = pop_data_i;

  always_comb begin
    if (cfg_i.bins_x == '0) begin
      nx = XW'(1);
    end else if (32'(cfg_i.bins_x) > MAX_BINS_X) begin
      nx = XW'(MAX_BINS_X);
    end else begin
      nx = XW'(cfg_i.bins_x);
    end
    if (cfg_i.bins_y == '0) begin
      ny = YW'(1);
    end else if (32'(cfg_i.bins_y) > MAX_BINS_Y) begin
      ny = YW'(MAX_BINS_Y);
    end else begin
      ny = YW'(cfg_i.bins_y);
    end
    if (32'(cfg_i.smooth_radius) > MAX_RADIUS) begin
      r = RAD_W'(MAX_RADIUS);
    end else begin
      r = cfg_i.smooth_radius;
    end
  end

  assign two_r = {r, 1'b0};

  // Clamped neighbors follow directly from the offset counter; the signed
  // raw position is x + k - r.
  assign px_raw = SXW'(cur_x_q) + SXW'(kx_q) - SXW'(r);
  assign py_raw = SYW'(cur_y_q) + SYW'(ky_q) - SYW'(r);

  always_comb begin
    if ($signed(px_raw) < $signed(SXW'(1))) begin
      px_clamp = XW'(1);
    end else if ($signed(px_raw) > $signed(SXW'(nx))) begin
      px_clamp = nx;
    end else begin
      px_clamp = XW'(px_raw);
    end
    if ($signed(py_raw) < $signed(SYW'(1))) begin
      py_clamp = YW'(1);
    end else if ($signed(py_raw) > $signed(SYW'(ny))) begin
      py_clamp = ny;
    end else begin
      py_clamp = YW'(py_raw);
    end
  end

  // Periodic neighbors are walked one step at a time, so any radius wraps
  // as often as it needs to.
  assign x_inc = (x_ptr_q == nx) ? XW'(1) : x_ptr_q + XW'(1);
  assign x_dec = (x_ptr_q == XW'(1)) ? nx : x_ptr_q - XW'(1);
  assign y_inc = (y_ptr_q == ny) ? YW'(1) : y_ptr_q + YW'(1);
  assign y_dec = (y_start_q == YW'(1)) ? ny : y_start_q - YW'(1);

  assign pop_ready_o  = (state_q == ST_IDLE);
  assign clear_busy_o = (state_q == ST_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign sum_o        = out_sum_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(e_y) * AW'(STRIDE) + AW'(e_x);
    ram_wdata = e_count;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (state_q == ST_IDLE && pop_valid_i && e_func == FUNC_WRITE) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = v1_q;
  assign ram_raddr = AW'(nby_q) * AW'(STRIDE) + AW'(nbx_q);

  hbs_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    cur_border_d = cur_border_q;
    x_ptr_d      = x_ptr_q;
    y_ptr_d      = y_ptr_q;
    y_start_d    = y_start_q;
    kx_d         = kx_q;
    ky_d         = ky_q;
    scnt_d       = scnt_q;
    v1_d         = 1'b0;
    last1_d      = 1'b0;
    nbx_d        = nbx_q;
    nby_d        = nby_q;
    acc_d        = acc_q;
    out_sum_d    = out_sum_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (v2_q) begin
      acc_d = acc_q + SUM_W'($signed(ram_rdata));
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_valid_i && e_func == FUNC_QUERY) begin
          cur_x_d      = e_x;
          cur_y_d      = e_y;
          cur_border_d = e_border;
          x_ptr_d      = e_x;
          y_ptr_d      = e_y;
          y_start_d    = e_y;
          kx_d         = '0;
          ky_d         = '0;
          scnt_d       = '0;
          acc_d        = '0;
          state_d      = (r == '0) ? ST_ISSUE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        // Back the periodic pointers up to the window's first neighbor.
        x_ptr_d   = x_dec;
        y_start_d = y_dec;
        y_ptr_d   = y_dec;
        scnt_d    = scnt_q + RAD_W'(1);
        if (scnt_q == r - RAD_W'(1)) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        v1_d    = 1'b1;
        last1_d = (kx_q == two_r) && (ky_q == two_r);
        if (cur_border_q) begin
          nbx_d = cur_x_q;
          nby_d = cur_y_q;
        end else begin
          nbx_d = cfg_i.x_periodic ? x_ptr_q : px_clamp;
          nby_d = cfg_i.y_periodic ? y_ptr_q : py_clamp;
        end
        if (ky_q == two_r) begin
          ky_d    = '0;
          kx_d    = kx_q + STEP_W'(1);
          y_ptr_d = y_start_q;
          x_ptr_d = x_inc;
          if (kx_q == two_r) begin
            state_d = ST_DRAIN;
          end
        end else begin
          ky_d    = ky_q + STEP_W'(1);
          y_ptr_d = y_inc;
        end
      end
      ST_DRAIN: begin
        if (v2_q && last2_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_sum_d   = acc_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      v1_q        <= 1'b0;
      last1_q     <= 1'b0;
      v2_q        <= 1'b0;
      last2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      cur_border_q <= cur_border_d;
      x_ptr_q      <= x_ptr_d;
      y_ptr_q      <= y_ptr_d;
      y_start_q    <= y_start_d;
      kx_q         <= kx_d;
      ky_q         <= ky_d;
      scnt_q       <= scnt_d;
      v1_q         <= v1_d;
      last1_q      <= last1_d;
      nbx_q        <= nbx_d;
      nby_q        <= nby_d;
      v2_q         <= v1_q;
      last2_q      <= last1_q;
      acc_q        <= acc_d;
      out_valid_q  <= out_valid_d;
      out_sum_q    <= out_sum_d;
    end
  end

endmodule

// ===== design/histogram_box_smoothing.sv =====
// Smoothed 2D histogram store with a box-window sum over its bins.
// Input channel (in_valid_i / in_ready_o) carries one request: func_i selects
// a write of count_in_i into bin (bin_x_i, bin_y_i), or a query of the sum of
// the (2r+1)x(2r+1) window around that bin. Only queries give a result, on
// the output channel (out_valid_o / out_ready_i, smoothed_sum_o), in order.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i; the
// user must do so only while the block is idle, which it does not enforce.
// Accepted requests wait in a two-entry queue; the executing side reads the
// bin store through its single read port, one bin per cycle. A query sets up
// its window pointers, reads the (2r+1)^2 bins of its window (225 at r = 7),
// drains the last reads and hands over its sum before the queue is popped
// again, so the query rate is set by the store's read port.
// After reset the store is swept to zero, one entry per cycle, over all
// (MAX_BINS_X+2)*(MAX_BINS_Y+2) entries (66564 at the default sizes);
// in_ready_o stays low during the sweep. A result waiting on a stalled
// receiver is held in the output register while the next requests are
// accepted and executed up to the point of handing over their own results.
module histogram_box_smoothing import hbs_pkg::*; #(
  parameter int unsigned MAX_BINS_X = 256,
  parameter int unsigned MAX_BINS_Y = 256,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [BIN_W-1:0]          bin_x_i,
  input  logic [BIN_W-1:0]          bin_y_i,
  input  logic signed [COUNT_W-1:0] count_in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SUM_W-1:0]   smoothed_sum_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned XW = $clog2(MAX_BINS_X + 2);
  localparam int unsigned YW = $clog2(MAX_BINS_Y + 2);
  localparam int unsigned EW = 2 + XW + YW + COUNT_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  cfg_t          cfg_q, cfg_d;
  logic          clear_busy;
  logic          push_valid, push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [EW-1:0] pop_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BINS_X:        cfg_d.bins_x        = cfg_wdata_i[BIN_W-1:0];
        CFG_BINS_Y:        cfg_d.bins_y        = cfg_wdata_i[BIN_W-1:0];
        CFG_SMOOTH_RADIUS: cfg_d.smooth_radius = cfg_wdata_i[RAD_W-1:0];
        CFG_X_PERIODIC:    cfg_d.x_periodic    = cfg_wdata_i[0];
        CFG_Y_PERIODIC:    cfg_d.y_periodic    = cfg_wdata_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bins_x        <= BINS_RESET;
      cfg_q.bins_y        <= BINS_RESET;
      cfg_q.smooth_radius <= RADIUS_RESET;
      cfg_q.x_periodic    <= 1'b0;
      cfg_q.y_periodic    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hbs_front #(
    .MAX_BINS_X (MAX_BINS_X),
    .MAX_BINS_Y (MAX_BINS_Y)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .bin_x_i      (bin_x_i),
    .bin_y_i      (bin_y_i),
    .count_in_i   (count_in_i),
    .cfg_i        (cfg_q),
    .clear_busy_i (clear_busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  hbs_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  hbs_back #(
    .MAX_BINS_X (MAX_BINS_X),
    .MAX_BINS_Y (MAX_BINS_Y),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sum_o        (smoothed_sum_o),
    .clear_busy_o (clear_busy)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hbs_pkg::*;

  localparam int NX_MAX           = 256;
  localparam int NY_MAX           = 256;
  localparam int R_MAX            = 7;
  localparam int STORE_STRIDE     = NX_MAX + 2;
  localparam int STORE_DEPTH      = (NX_MAX + 2) * (NY_MAX + 2);
  localparam int NUM_PHASES       = 13;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int HOLD_CYCLES      = 600;
  localparam int DRAIN_CYCLES     = 20;
  localparam int MAX_REPORTS      = 100;
  // The clearing sweep after reset alone clears 66564 entries with nothing accepted.
  localparam int WATCHDOG_LIMIT   = 300000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct {
    func_e                      func;
    logic [BIN_W-1:0]           x;
    logic [BIN_W-1:0]           y;
    logic signed [COUNT_W-1:0]  count;
  } bin_req_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    int                      x;
    int                      y;
  } window_sum_t;

  logic                      clk_i;
  logic                      rst_ni    = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic                      req_func  = 1'b0;
  logic [BIN_W-1:0]          req_bin_x = '0;
  logic [BIN_W-1:0]          req_bin_y = '0;
  logic signed [COUNT_W-1:0] req_count = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SUM_W-1:0]   smoothed_sum;
  logic                      cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

  // Shadow of the block: configuration and bin counts (cleared, as after reset).
  cfg_t cfg_shadow;
  int   bin_mem [STORE_DEPTH];

  bin_req_t    pending_reqs [$];
  window_sum_t expected_sums [$];
  bin_req_t    cur_req;

  int send_gap       = 0;
  int recv_stall     = 0;
  int hold_left      = 0;
  int send_idle_pct  = 25;
  int recv_idle_pct  = 25;
  bit hold_request   = 1'b0;
  bit hold_seen      = 1'b0;
  int idle_cycles    = 0;
  int mismatch_count = 0;
  int sums_checked   = 0;
  int writes_done    = 0;
  int queries_done   = 0;

  histogram_box_smoothing i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (req_func),
    .bin_x_i        (req_bin_x),
    .bin_y_i        (req_bin_y),
    .count_in_i     (req_count),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .smoothed_sum_o (smoothed_sum),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_bins(logic [BIN_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Neighbor index along one axis for a real bin, clamped or wrapped at the edges.
  function automatic int neighbor_bin(int pos, int off, int n, logic periodic);
    int p;
    int m;
    p = pos + off;
    if (p >= 1 && p <= n) return p;
    if (!periodic) return (p < 1) ? 1 : n;
    m = (p - 1) % n;
    if (m < 0) m += n;
    return m + 1;
  endfunction

  // Applies one accepted request to the shadow store; a query yields its window sum.
  function automatic void apply_request(bin_req_t req);
    int          nx;
    int          ny;
    int          r;
    int          x;
    int          y;
    int          side;
    int          nxp;
    int          nyp;
    longint      acc;
    window_sum_t e;
    nx = eff_bins(cfg_shadow.bins_x, NX_MAX);
    ny = eff_bins(cfg_shadow.bins_y, NY_MAX);
    r  = (cfg_shadow.smooth_radius > R_MAX) ? R_MAX : int'(cfg_shadow.smooth_radius);
    x  = int'(req.x);
    y  = int'(req.y);
    if (x > nx + 1) x = nx + 1;
    if (y > ny + 1) y = ny + 1;
    if (req.func == FUNC_WRITE) begin
      bin_mem[y * STORE_STRIDE + x] = req.count;
      writes_done++;
      return;
    end
    acc = 0;
    if (x == 0 || y == 0 || x == nx + 1 || y == ny + 1) begin
      // A border bin is its own neighbor everywhere in the window.
      side = 2 * r + 1;
      acc = longint'(side * side) * longint'(bin_mem[y * STORE_STRIDE + x]);
    end else begin
      for (int i = -r; i <= r; i++) begin
        nxp = neighbor_bin(x, i, nx, cfg_shadow.x_periodic);
        for (int j = -r; j <= r; j++) begin
          nyp = neighbor_bin(y, j, ny, cfg_shadow.y_periodic);
          acc += longint'(bin_mem[nyp * STORE_STRIDE + nxp]);
        end
      end
    end
    e.sum = acc[SUM_W-1:0];
    e.x   = x;
    e.y   = y;
    expected_sums.push_back(e);
    queries_done++;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) apply_request(cur_req);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          req_func  <= cur_req.func;
          req_bin_x <= cur_req.x;
          req_bin_y <= cur_req.y;
          req_count <= cur_req.count;
          if ($urandom_range(99) < send_idle_pct) send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    window_sum_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("window sum %0d with no query waiting", smoothed_sum));
        end else begin
          e = expected_sums.pop_front();
          sums_checked++;
          if (smoothed_sum !== e.sum)
            report_mismatch($sformatf("query (%0d,%0d): window sum %0d, predicted %0d",
                                      e.x, e.y, smoothed_sum, e.sum));
        end
      end
      if (hold_request && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < recv_idle_pct) begin
        recv_stall = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: nothing moved for %0d cycles, %0d window sums outstanding.",
                 WATCHDOG_LIMIT, expected_sums.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid || expected_sums.size() != 0);
    // Trailing writes give no result and may still be in flight.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(logic [BIN_W-1:0] bx, logic [BIN_W-1:0] by,
                            logic [RAD_W-1:0] rad, logic xp, logic yp);
    wait_idle();
    write_cfg(CFG_BINS_X, bx);
    write_cfg(CFG_BINS_Y, by);
    write_cfg(CFG_SMOOTH_RADIUS, CFG_DATA_W'(rad));
    write_cfg(CFG_X_PERIODIC, CFG_DATA_W'(xp));
    write_cfg(CFG_Y_PERIODIC, CFG_DATA_W'(yp));
    cfg_shadow.bins_x        = bx;
    cfg_shadow.bins_y        = by;
    cfg_shadow.smooth_radius = rad;
    cfg_shadow.x_periodic    = xp;
    cfg_shadow.y_periodic    = yp;
  endtask

  task automatic push_req(func_e f, int x, int y, logic signed [COUNT_W-1:0] c);
    bin_req_t req;
    req.func  = f;
    req.x     = x[BIN_W-1:0];
    req.y     = y[BIN_W-1:0];
    req.count = c;
    pending_reqs.push_back(req);
  endtask

  // Mostly in-range coordinates; on wide axes, most land near the low edge so
  // that windows overlap written bins.
  function automatic int pick_coord(int n);
    int c;
    c = $urandom_range(99);
    if (c < 12) return $urandom_range(0, 511);
    if (n > 24 && c < 70) return $urandom_range(0, 20);
    return $urandom_range(0, n + 1);
  endfunction

  function automatic logic signed [COUNT_W-1:0] pick_count();
    int c;
    c = $urandom_range(99);
    if (c < 8) return 32'sh7FFF_FFFF;
    if (c < 16) return 32'sh8000_0000;
    if (c < 22) return -32'sd1;
    if (c < 45) return $urandom;
    return $signed($urandom_range(0, 2000)) - 1000;
  endfunction

  function automatic logic [BIN_W-1:0] pick_bins();
    int c;
    c = $urandom_range(99);
    if (c < 10) return '0;
    if (c < 75) return BIN_W'($urandom_range(1, 24));
    return BIN_W'($urandom_range(25, 511));
  endfunction

  initial begin
    logic [BIN_W-1:0] bx;
    logic [BIN_W-1:0] by;
    logic [RAD_W-1:0] rad;
    logic             xp;
    logic             yp;
    int               nx;
    int               ny;

    cfg_shadow.bins_x        = BINS_RESET;
    cfg_shadow.bins_y        = BINS_RESET;
    cfg_shadow.smooth_radius = RADIUS_RESET;
    cfg_shadow.x_periodic    = 1'b0;
    cfg_shadow.y_periodic    = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests at the reset configuration: extreme counts, border
    // bins, indexes above the overflow bin and windows touching the edges.
    push_req(FUNC_WRITE, 1, 1, 32'sh7FFF_FFFF);
    push_req(FUNC_WRITE, 2, 1, 32'sh8000_0000);
    push_req(FUNC_WRITE, 1, 2, -32'sd1);
    push_req(FUNC_WRITE, 0, 0, 32'sh7FFF_FFFF);
    push_req(FUNC_WRITE, 257, 257, 32'sh8000_0000);
    push_req(FUNC_WRITE, 256, 256, 32'sd12345);
    push_req(FUNC_WRITE, 511, 100, 32'sd777);
    push_req(FUNC_QUERY, 1, 1, '0);
    push_req(FUNC_QUERY, 2, 2, '1);
    push_req(FUNC_QUERY, 0, 0, '0);
    push_req(FUNC_QUERY, 257, 257, '0);
    push_req(FUNC_QUERY, 511, 511, '0);
    push_req(FUNC_QUERY, 300, 100, '0);
    push_req(FUNC_QUERY, 256, 256, '0);
    push_req(FUNC_QUERY, 0, 5, '0);
    push_req(FUNC_QUERY, 128, 0, '0);
    push_req(FUNC_WRITE, 128, 128, 32'sh5555_5555);
    push_req(FUNC_QUERY, 128, 128, '0);
    push_req(FUNC_QUERY, 129, 127, '0);
    push_req(FUNC_WRITE, 255, 255, 32'shAAAA_AAAA);
    push_req(FUNC_QUERY, 256, 255, '0);
    push_req(FUNC_QUERY, 255, 256, '0);

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          // Radius far wider than both axes, wrapping several times.
          bx = 9'd4; by = 9'd3; rad = 3'd7; xp = 1'b1; yp = 1'b1;
        end
        2: begin
          bx = 9'd0; by = 9'd1; rad = 3'd2; xp = 1'b0; yp = 1'b0;
        end
        3: begin
          bx = 9'd511; by = 9'd256; rad = 3'd0; xp = 1'b1; yp = 1'b0;
        end
        4: begin
          bx = 9'd16; by = 9'd9; rad = 3'd3; xp = 1'b0; yp = 1'b1;
        end
        5: begin
          bx = 9'd256; by = 9'd1; rad = 3'd5; xp = 1'b1; yp = 1'b1;
        end
        NUM_PHASES: begin
          bx = 9'd12; by = 9'd12; rad = 3'd7; xp = 1'b1; yp = 1'b0;
        end
        default: begin
          bx  = pick_bins();
          by  = pick_bins();
          rad = RAD_W'($urandom_range(0, 7));
          xp  = 1'($urandom_range(0, 1));
          yp  = 1'($urandom_range(0, 1));
        end
      endcase
      set_config(bx, by, rad, xp, yp);
      // A write to an index past the register list must change nothing.
      if (phase == 2) write_cfg(CFG_IDX_UNUSED, '1);

      @(negedge clk_i);
      if (phase == NUM_PHASES || phase % 3 == 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(10, 40);
        recv_idle_pct = $urandom_range(10, 40);
      end
      // The receiver holds off long enough for the block to stall its input.
      if (phase == 4) hold_request = 1'b1;

      nx = eff_bins(bx, NX_MAX);
      ny = eff_bins(by, NY_MAX);
      for (int k = 0; k < RANDOM_PER_PHASE; k++)
        push_req(($urandom_range(99) < 45) ? FUNC_WRITE : FUNC_QUERY,
                 pick_coord(nx), pick_coord(ny), pick_count());
    end

    wait_idle();
    $display("Ran %0d requests (%0d writes, %0d queries) over %0d register settings,",
             writes_done + queries_done, writes_done, queries_done, NUM_PHASES + 1);
    $display("with clamped and wrapped edges, border bins and radii 0 to 7; %0d sums checked.",
             sums_checked);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
